FILE: src/tsrra_pkg.sv
// ----------------------------------------------------------------------------
// tsrra_pkg
// Shared types and constants of the timestamp round-robin arbiter: field
// widths, item modes, result codes, sequencer states and control structs.
// ----------------------------------------------------------------------------
package tsrra_pkg;

  localparam int MAX_SOURCES = 8;
  localparam int SRC_BITS    = $clog2(MAX_SOURCES);
  localparam int TIME_BITS   = 32;
  localparam int CNT_BITS    = 4;
  localparam int DELAY_BITS  = 16;
  localparam int CFG_BITS    = 16;

  localparam logic [CNT_BITS-1:0] SRC_COUNT_MAX = CNT_BITS'(MAX_SOURCES);
  localparam logic [CNT_BITS-1:0] SRC_COUNT_RST = CNT_BITS'(8);

  localparam logic CFG_SOURCE_COUNT = 1'b0;
  localparam logic CFG_LINK_DELAY   = 1'b1;

  typedef enum logic [1:0] {
    MODE_PUT    = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_ARB    = 2'd2,
    MODE_DONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_NONE   = 2'd0,
    STAT_WAIT   = 2'd1,
    STAT_GRANT  = 2'd2,
    STAT_ACCEPT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_SCAN,
    S_RESOLVE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic reduce_step;
    logic scan_init;
    logic scan_step;
    logic resolve;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_arb;
    logic n_zero;
    logic ptr_ge_n;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: src/tsrra_ctrl.sv
// ----------------------------------------------------------------------------
// tsrra_ctrl
// Sequencer of the arbiter: takes a transaction, steps the pointer
// reduction and the source scan, resolves and hands the result out.
// ----------------------------------------------------------------------------
module tsrra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tsrra_pkg::dp_stat_t stat,
  output tsrra_pkg::dp_cmd_t  cmd,
  output tsrra_pkg::state_t   state
);
  import tsrra_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.in_arb && !stat.n_zero) begin
            state_nxt = S_REDUCE;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_REDUCE: begin
        if (!stat.ptr_ge_n) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.capture = in_valid;
      end
      S_REDUCE: begin
        cmd.reduce_step = stat.ptr_ge_n;
        cmd.scan_init = !stat.ptr_ge_n;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
      end
      S_FINISH: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign state = state_r;

endmodule

FILE: src/tsrra_dpath.sv
// ----------------------------------------------------------------------------
// tsrra_dpath
// Source tables, configuration, scan trackers and result/output registers
// of the arbiter.
// ----------------------------------------------------------------------------
module tsrra_dpath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [tsrra_pkg::CFG_BITS-1:0]      cfg_wdata,
  input  logic [1:0]                          in_mode,
  input  logic [tsrra_pkg::SRC_BITS-1:0]      in_source,
  input  logic [tsrra_pkg::TIME_BITS-1:0]     in_stamp,
  input  logic                                in_active,
  input  tsrra_pkg::dp_cmd_t                  cmd,
  output tsrra_pkg::dp_stat_t                 stat,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [tsrra_pkg::SRC_BITS-1:0]      out_grant_source,
  output logic [tsrra_pkg::TIME_BITS-1:0]     out_send_time
);
  import tsrra_pkg::*;

  logic [CNT_BITS-1:0]   src_count_r;
  logic [DELAY_BITS-1:0] link_delay_r;

  logic [MAX_SOURCES-1:0] pend_flag_r;
  logic [TIME_BITS-1:0]   pend_time_r [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] src_active_r;
  logic [TIME_BITS-1:0]   src_time_r [MAX_SOURCES];
  logic [TIME_BITS-1:0]   local_time_r;
  logic [SRC_BITS-1:0]    rr_ptr_r;

  logic [SRC_BITS-1:0]  ptr_w_r;
  logic [SRC_BITS-1:0]  k_r;
  logic [SRC_BITS-1:0]  j_r;
  logic                 have_min_r;
  logic                 min_pend_r;
  logic [SRC_BITS-1:0]  min_idx_r;
  logic [TIME_BITS-1:0] min_time_r;
  logic                 have_hp_r;
  logic [SRC_BITS-1:0]  hp_idx_r;
  logic [TIME_BITS-1:0] hp_time_r;
  logic                 any_pend_r;

  status_t              res_status_r;
  logic [SRC_BITS-1:0]  res_src_r;
  logic [TIME_BITS-1:0] res_time_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [SRC_BITS-1:0]  out_src_r;
  logic [TIME_BITS-1:0] out_time_r;

  mode_t                mode_in;
  logic [CNT_BITS-1:0]  n_eff;
  logic [SRC_BITS-1:0]  n_last;
  logic [SRC_BITS-1:0]  k_dec;
  logic [TIME_BITS:0]   idle_sum;
  logic [TIME_BITS-1:0] idle_time;
  logic                 cur_act;
  logic                 cur_pend;
  logic [TIME_BITS-1:0] cur_time;
  logic                 take_new;
  logic                 take_tie;
  logic [TIME_BITS-1:0] grant_time;
  logic [SRC_BITS-1:0]  min_next;

  assign mode_in = mode_t'(in_mode);
  assign n_eff   = (src_count_r > SRC_COUNT_MAX) ? SRC_COUNT_MAX : src_count_r;
  assign n_last  = SRC_BITS'(n_eff - CNT_BITS'(1));
  assign k_dec   = (k_r == '0) ? n_last : k_r - SRC_BITS'(1);

  assign idle_sum  = {1'b0, src_time_r[k_r]}
                   + {{(TIME_BITS - DELAY_BITS + 1){1'b0}}, link_delay_r};
  assign idle_time = idle_sum[TIME_BITS] ? '1 : idle_sum[TIME_BITS-1:0];
  assign cur_act   = src_active_r[k_r];
  assign cur_pend  = pend_flag_r[k_r];
  assign cur_time  = cur_pend ? pend_time_r[k_r] : idle_time;
  assign take_new  = !have_min_r || (cur_time < min_time_r);
  assign take_tie  = (cur_time == min_time_r) && !min_pend_r;

  assign grant_time = have_hp_r ? hp_time_r : min_time_r;
  assign min_next   = (CNT_BITS'(min_idx_r) == n_eff - CNT_BITS'(1)) ? '0
                    : min_idx_r + SRC_BITS'(1);

  assign stat.in_arb    = (mode_in == MODE_ARB);
  assign stat.n_zero    = (n_eff == '0);
  assign stat.ptr_ge_n  = ({1'b0, ptr_w_r} >= n_eff);
  assign stat.scan_last = (j_r == '0);
  assign stat.out_free  = !out_valid_r || !out_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_count_r  <= SRC_COUNT_RST;
      link_delay_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SOURCE_COUNT: src_count_r  <= cfg_wdata[CNT_BITS-1:0];
        CFG_LINK_DELAY:   link_delay_r <= cfg_wdata[DELAY_BITS-1:0];
        default:          ;
      endcase
    end
  end

  // source tables and local time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_flag_r  <= '0;
      src_active_r <= '0;
      local_time_r <= '0;
      for (int i = 0; i < MAX_SOURCES; i++) begin
        pend_time_r[i] <= '0;
        src_time_r[i]  <= '0;
      end
    end else if (cmd.capture) begin
      unique case (mode_in)
        MODE_PUT: begin
          pend_flag_r[in_source] <= 1'b1;
          pend_time_r[in_source] <= in_stamp;
        end
        MODE_UPDATE: begin
          src_active_r[in_source] <= in_active;
          src_time_r[in_source]   <= in_stamp;
        end
        MODE_DONE: begin
          pend_flag_r[in_source] <= 1'b0;
          local_time_r           <= in_stamp;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_ptr_r <= '0;
    end else if (cmd.resolve && any_pend_r && !have_hp_r && min_pend_r) begin
      rr_ptr_r <= min_next;
    end
  end

  // pointer reduction and scan trackers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ptr_w_r <= rr_ptr_r;
    end else if (cmd.reduce_step) begin
      ptr_w_r <= SRC_BITS'({1'b0, ptr_w_r} - n_eff);
    end

    if (cmd.scan_init) begin
      k_r        <= (ptr_w_r == '0) ? n_last : ptr_w_r - SRC_BITS'(1);
      j_r        <= n_last;
      have_min_r <= 1'b0;
      min_pend_r <= 1'b0;
      min_idx_r  <= '0;
      min_time_r <= '0;
      have_hp_r  <= 1'b0;
      hp_idx_r   <= '0;
      hp_time_r  <= '0;
      any_pend_r <= 1'b0;
    end else if (cmd.scan_step) begin
      k_r <= k_dec;
      j_r <= j_r - SRC_BITS'(1);
      if (cur_act) begin
        if (take_new) begin
          have_min_r <= 1'b1;
          min_time_r <= cur_time;
          min_idx_r  <= k_r;
          min_pend_r <= cur_pend;
        end else if (take_tie) begin
          min_idx_r  <= k_r;
          min_pend_r <= cur_pend;
        end
        if (cur_pend) begin
          any_pend_r <= 1'b1;
          if (cur_time <= local_time_r) begin
            have_hp_r <= 1'b1;
            hp_idx_r  <= k_r;
            hp_time_r <= cur_time;
          end
        end
      end
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status_r <= (mode_in == MODE_ARB) ? STAT_NONE : STAT_ACCEPT;
      res_src_r    <= '0;
      res_time_r   <= '0;
    end else if (cmd.resolve) begin
      if (!any_pend_r) begin
        res_status_r <= STAT_NONE;
      end else if (have_hp_r || min_pend_r) begin
        res_status_r <= STAT_GRANT;
        res_src_r    <= have_hp_r ? hp_idx_r : min_idx_r;
        res_time_r   <= (grant_time < local_time_r) ? local_time_r : grant_time;
      end else begin
        res_status_r <= STAT_WAIT;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_src_r    <= res_src_r;
      out_time_r   <= res_time_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_grant_source = out_src_r;
  assign out_send_time    = out_time_r;

endmodule

FILE: src/timestamp_round_robin_arbiter_core.sv
// ----------------------------------------------------------------------------
// timestamp_round_robin_arbiter_core
// put, update and complete skip the scan and load their result from the finish state
// arbitrate: r pointer reductions (0-7), a scan of the n sources in use, then resolve; n = 0 skips to finish
// the scan reads one source entry per cycle
// one transaction in flight: the next is taken the cycle after the result loads
// reset (synchronous, active low) clears tables, local time, pointer and config
// ----------------------------------------------------------------------------
module timestamp_round_robin_arbiter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [tsrra_pkg::CFG_BITS-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_mode,
  input  logic [tsrra_pkg::SRC_BITS-1:0]  in_source,
  input  logic [tsrra_pkg::TIME_BITS-1:0] in_stamp,
  input  logic                            in_active,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [tsrra_pkg::SRC_BITS-1:0]  out_grant_source,
  output logic [tsrra_pkg::TIME_BITS-1:0] out_send_time
);
  import tsrra_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  state_t   state;

  tsrra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd),
    .state    (state)
  );

  tsrra_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_mode),
    .in_source        (in_source),
    .in_stamp         (in_stamp),
    .in_active        (in_active),
    .cmd              (cmd),
    .stat             (stat),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_grant_source (out_grant_source),
    .out_send_time    (out_send_time)
  );

  // one transaction in flight
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("transaction accepted while another in flight");

  // result loads only from the finish state
  a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> state == S_FINISH && !in_stall == 1'b0)
    else $error("result loaded outside finish state");

  // non-grant results carry no source or time
  a_nongrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_GRANT |-> out_grant_source == '0 && out_send_time == '0)
    else $error("non-grant result with source or time set");

endmodule
